FILE: hw/rtl/rotated_rectangle_collision_top_macros.svh
// assertion helpers for the rectangle overlap block
`ifndef ROTATED_RECTANGLE_COLLISION_TOP_MACROS_SVH
`define ROTATED_RECTANGLE_COLLISION_TOP_MACROS_SVH

// condition holds in the same cycle as the trigger
`define RRC_ASSERT_SAME(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("rrc check failed: same-cycle implication");

// condition holds in the cycle after the trigger
`define RRC_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("rrc check failed: next-cycle implication");

`endif

FILE: hw/rtl/rrc_pkg.sv
`timescale 1ns / 1ps

package rrc_pkg;

	localparam int COORD_WIDTH_DEF = 14;
	localparam int NUM_CORNERS     = 4;
	localparam int NUM_AXES        = 4;

	// meaning of the action bit
	typedef enum logic {
		ACTION_LOAD = 1'b0,
		ACTION_TEST = 1'b1
	} action_t;

	// per-stage load enables of the projection pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

FILE: hw/rtl/rrc_cmd_if.sv
`timescale 1ns / 1ps

interface rrc_cmd_if #(
	parameter int CW = rrc_pkg::COORD_WIDTH_DEF
);
	logic              valid;
	logic              ready;
	logic              action;
	logic signed [CW-1:0] corner1_x;
	logic signed [CW-1:0] corner1_y;
	logic signed [CW-1:0] corner2_x;
	logic signed [CW-1:0] corner2_y;
	logic signed [CW-1:0] corner3_x;
	logic signed [CW-1:0] corner3_y;
	logic signed [CW-1:0] corner4_x;
	logic signed [CW-1:0] corner4_y;

	modport source (
		output valid, action,
		output corner1_x, corner1_y, corner2_x, corner2_y,
		output corner3_x, corner3_y, corner4_x, corner4_y,
		input  ready
	);

	modport sink (
		input  valid, action,
		input  corner1_x, corner1_y, corner2_x, corner2_y,
		input  corner3_x, corner3_y, corner4_x, corner4_y,
		output ready
	);
endinterface

FILE: hw/rtl/rrc_res_if.sv
`timescale 1ns / 1ps

interface rrc_res_if;
	logic valid;
	logic ready;
	logic colliding;

	modport source (
		output valid, colliding,
		input  ready
	);

	modport sink (
		input  valid, colliding,
		output ready
	);
endinterface

FILE: hw/rtl/rrc_axis.sv
`timescale 1ns / 1ps

// projects both corner sets onto one axis and flags a separating gap
module rrc_axis #(
	parameter int CW = rrc_pkg::COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  rrc_pkg::stage_en_t    en,
	input  logic signed [CW-1:0]  ax [rrc_pkg::NUM_CORNERS],
	input  logic signed [CW-1:0]  ay [rrc_pkg::NUM_CORNERS],
	input  logic signed [CW-1:0]  bx [rrc_pkg::NUM_CORNERS],
	input  logic signed [CW-1:0]  by [rrc_pkg::NUM_CORNERS],
	input  logic signed [CW:0]    dx,
	input  logic signed [CW:0]    dy,
	output logic                  sep
);
	import rrc_pkg::*;

	localparam int PW = 2 * CW + 1;
	localparam int SW = 2 * CW + 2;

	logic signed [PW-1:0] pax_s2 [NUM_CORNERS];
	logic signed [PW-1:0] pay_s2 [NUM_CORNERS];
	logic signed [PW-1:0] pbx_s2 [NUM_CORNERS];
	logic signed [PW-1:0] pby_s2 [NUM_CORNERS];
	logic signed [SW-1:0] pa_s3  [NUM_CORNERS];
	logic signed [SW-1:0] pb_s3  [NUM_CORNERS];
	logic signed [SW-1:0] amin_s4, amax_s4, bmin_s4, bmax_s4;

	function automatic logic signed [SW-1:0] min2(input logic signed [SW-1:0] a,
	                                              input logic signed [SW-1:0] b);
		min2 = (a < b) ? a : b;
	endfunction

	function automatic logic signed [SW-1:0] max2(input logic signed [SW-1:0] a,
	                                              input logic signed [SW-1:0] b);
		max2 = (a > b) ? a : b;
	endfunction

	// coordinate times axis component, one product per register
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				pax_s2[k] <= PW'(ax[k]) * PW'(dx);
				pay_s2[k] <= PW'(ay[k]) * PW'(dy);
				pbx_s2[k] <= PW'(bx[k]) * PW'(dx);
				pby_s2[k] <= PW'(by[k]) * PW'(dy);
			end
		end
	end

	// dot products
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				pa_s3[k] <= SW'(pax_s2[k]) + SW'(pay_s2[k]);
				pb_s3[k] <= SW'(pbx_s2[k]) + SW'(pby_s2[k]);
			end
		end
	end

	// interval ends of each rectangle, two-level compare tree
	always_ff @(posedge clk) begin
		if (en.s4) begin
			amin_s4 <= min2(min2(pa_s3[0], pa_s3[1]), min2(pa_s3[2], pa_s3[3]));
			amax_s4 <= max2(max2(pa_s3[0], pa_s3[1]), max2(pa_s3[2], pa_s3[3]));
			bmin_s4 <= min2(min2(pb_s3[0], pb_s3[1]), min2(pb_s3[2], pb_s3[3]));
			bmax_s4 <= max2(max2(pb_s3[0], pb_s3[1]), max2(pb_s3[2], pb_s3[3]));
		end
	end

	// gap between intervals; touching does not separate
	assign sep = (bmin_s4 > amax_s4) || (amin_s4 > bmax_s4);

endmodule

FILE: hw/rtl/rotated_rectangle_collision_top.sv
`timescale 1ns / 1ps
// channel | dir | payload                                   | handshake
// cmd     | in  | action, corner1..4 x/y (COORD_WIDTH, s)   | valid/ready
// res     | out | colliding                                 | valid/ready
//
// One item per cycle unless res stalls; a test result passes registers s1 to s5 in turn.
// A load updates the reference at its transfer and yields no result.
// Reset clears the reference rectangle to zero and empties the pipeline.
// Each stage advances when it is empty or the next one moves, so bubbles are
// absorbed and a stalled result is held in the output register.

`include "rotated_rectangle_collision_top_macros.svh"

module rotated_rectangle_collision_top #(
	parameter int COORD_WIDTH = rrc_pkg::COORD_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	rrc_cmd_if.sink          cmd,
	rrc_res_if.source        res
);
	import rrc_pkg::*;

	localparam int CW = COORD_WIDTH;

	logic signed [CW-1:0] ref_x_q [NUM_CORNERS];
	logic signed [CW-1:0] ref_y_q [NUM_CORNERS];
	logic signed [CW-1:0] bx_in   [NUM_CORNERS];
	logic signed [CW-1:0] by_in   [NUM_CORNERS];

	logic signed [CW-1:0] ax_s1 [NUM_CORNERS];
	logic signed [CW-1:0] ay_s1 [NUM_CORNERS];
	logic signed [CW-1:0] bx_s1 [NUM_CORNERS];
	logic signed [CW-1:0] by_s1 [NUM_CORNERS];
	logic signed [CW:0]   dx_s1 [NUM_AXES];
	logic signed [CW:0]   dy_s1 [NUM_AXES];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic colliding_s5;
	logic cmd_xfer, load_xfer, test_xfer;
	logic [NUM_AXES-1:0] sep;
	stage_en_t en;

	assign bx_in[0] = cmd.corner1_x;
	assign bx_in[1] = cmd.corner2_x;
	assign bx_in[2] = cmd.corner3_x;
	assign bx_in[3] = cmd.corner4_x;
	assign by_in[0] = cmd.corner1_y;
	assign by_in[1] = cmd.corner2_y;
	assign by_in[2] = cmd.corner3_y;
	assign by_in[3] = cmd.corner4_y;

	// stage flow control
	assign rdy5 = !v_s5 || res.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign en   = '{s2: rdy2, s3: rdy3, s4: rdy4};

	assign cmd.ready = rdy1;
	assign cmd_xfer  = cmd.valid && rdy1;
	assign load_xfer = cmd_xfer && (cmd.action == ACTION_LOAD);
	assign test_xfer = cmd_xfer && (cmd.action == ACTION_TEST);

	// reference rectangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				ref_x_q[k] <= '0;
				ref_y_q[k] <= '0;
			end
		end else if (load_xfer) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				ref_x_q[k] <= bx_in[k];
				ref_y_q[k] <= by_in[k];
			end
		end
	end

	// input register: corners of both rectangles and the NUM_AXES edge axes
	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int k = 0; k < NUM_CORNERS; k++) begin
				ax_s1[k] <= ref_x_q[k];
				ay_s1[k] <= ref_y_q[k];
				bx_s1[k] <= bx_in[k];
				by_s1[k] <= by_in[k];
			end
			dx_s1[0] <= (CW+1)'(ref_x_q[0]) - (CW+1)'(ref_x_q[1]);
			dy_s1[0] <= (CW+1)'(ref_y_q[0]) - (CW+1)'(ref_y_q[1]);
			dx_s1[1] <= (CW+1)'(ref_x_q[0]) - (CW+1)'(ref_x_q[2]);
			dy_s1[1] <= (CW+1)'(ref_y_q[0]) - (CW+1)'(ref_y_q[2]);
			dx_s1[2] <= (CW+1)'(bx_in[0]) - (CW+1)'(bx_in[1]);
			dy_s1[2] <= (CW+1)'(by_in[0]) - (CW+1)'(by_in[1]);
			dx_s1[3] <= (CW+1)'(bx_in[0]) - (CW+1)'(bx_in[2]);
			dy_s1[3] <= (CW+1)'(by_in[0]) - (CW+1)'(by_in[2]);
		end
	end

	// one projection unit per axis
	for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
		rrc_axis #(
			.CW (CW)
		) u_axis (
			.clk (clk),
			.en  (en),
			.ax  (ax_s1),
			.ay  (ay_s1),
			.bx  (bx_s1),
			.by  (by_s1),
			.dx  (dx_s1[g]),
			.dy  (dy_s1[g]),
			.sep (sep[g])
		);
	end

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= test_xfer;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// result register: collide unless some axis separates
	always_ff @(posedge clk) begin
		if (rdy5) begin
			colliding_s5 <= ~|sep;
		end
	end

	assign res.valid     = v_s5;
	assign res.colliding = colliding_s5;

	// a load never enters the pipeline
	`RRC_ASSERT_NEXT(a_load_no_item, clk, arst_n, load_xfer, !v_s1)
	// a load is visible in the reference in the following cycle
	`RRC_ASSERT_NEXT(a_load_stored, clk, arst_n, load_xfer,
		ref_x_q[0] == $past(cmd.corner1_x) && ref_y_q[3] == $past(cmd.corner4_y))
	// back-pressure only while the first stage holds an item
	`RRC_ASSERT_SAME(a_ready_low_full, clk, arst_n, !cmd.ready, v_s1 && v_s2)

endmodule
